// ----- rtl/sll_pkg.sv -----
`timescale 1ns / 1ps

package sll_pkg;

  localparam int NODE_SLOTS = 128;
  localparam int IDX_W      = $clog2(NODE_SLOTS);
  localparam int DATA_W     = 32;
  localparam int OUT_IDX_W  = 7;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RD_FREE = 2'd0,
    RD_USED = 2'd1,
    RD_NEXT = 2'd2
  } rd_src_t;

  typedef struct packed {
    logic    clr_wr;
    logic    load;
    logic    rd_en;
    rd_src_t rd_src;
    logic    walk_init;
    logic    walk_adv;
    logic    ins_commit;
    logic    unlink;
    logic    free_node;
    logic    emit;
    status_t emit_st;
  } sll_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic free_empty;
    logic used_empty;
    logic match;
    logic next_zero;
  } sll_stat_t;

  function automatic logic [OUT_IDX_W-1:0] to_out(input idx_t x);
    logic [31:0] t;
    t = 32'(x);
    return t[OUT_IDX_W-1:0];
  endfunction

endpackage

// ----- rtl/sll_ctrl.sv -----
`timescale 1ns / 1ps

module sll_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_op,
  input  sll_pkg::sll_stat_t stat,
  output sll_pkg::sll_cmd_t  cmd,
  output logic              busy
);
  import sll_pkg::*;

  typedef enum logic [7:0] {
    S_CLEAR      = 8'b0000_0001,
    S_IDLE       = 8'b0000_0010,
    S_INS_RD     = 8'b0000_0100,
    S_INS_WR     = 8'b0000_1000,
    S_DEL_RD     = 8'b0001_0000,
    S_DEL_CMP    = 8'b0010_0000,
    S_DEL_UNLINK = 8'b0100_0000,
    S_DEL_FREE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.rd_src  = RD_FREE;
    cmd.emit_st = ST_DONE;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (!in_op) begin
            state_nxt = S_INS_RD;
          end else begin
            cmd.walk_init = 1'b1;
            state_nxt     = S_DEL_RD;
          end
        end
      end
      S_INS_RD: begin
        if (stat.free_empty) begin
          cmd.emit    = 1'b1;
          cmd.emit_st = ST_FULL;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_FREE;
          state_nxt  = S_INS_WR;
        end
      end
      S_INS_WR: begin
        cmd.ins_commit = 1'b1;
        cmd.emit       = 1'b1;
        cmd.emit_st    = ST_DONE;
        state_nxt      = S_IDLE;
      end
      S_DEL_RD: begin
        if (stat.used_empty) begin
          cmd.emit    = 1'b1;
          cmd.emit_st = ST_NOT_FOUND;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_USED;
          state_nxt  = S_DEL_CMP;
        end
      end
      S_DEL_CMP: begin
        if (stat.match) begin
          state_nxt = S_DEL_UNLINK;
        end else if (stat.next_zero) begin
          cmd.emit    = 1'b1;
          cmd.emit_st = ST_NOT_FOUND;
          state_nxt   = S_IDLE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_src   = RD_NEXT;
          cmd.walk_adv = 1'b1;
        end
      end
      S_DEL_UNLINK: begin
        cmd.unlink = 1'b1;
        state_nxt  = S_DEL_FREE;
      end
      S_DEL_FREE: begin
        cmd.free_node = 1'b1;
        cmd.emit      = 1'b1;
        cmd.emit_st   = ST_DONE;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- rtl/sll_datapath.sv -----
`timescale 1ns / 1ps

module sll_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic signed [31:0]    in_value,
  input  sll_pkg::sll_cmd_t     cmd,
  output sll_pkg::sll_stat_t    stat,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic [6:0]            out_node_index,
  output logic [6:0]            out_item_count
);
  import sll_pkg::*;

  localparam idx_t LAST_IDX = IDX_W'(NODE_SLOTS - 1);
  localparam idx_t FREE_TOP = IDX_W'(2);

  logic signed [DATA_W-1:0] data_mem [NODE_SLOTS];
  idx_t                     link_mem [NODE_SLOTS];

  logic signed [DATA_W-1:0] value_r;
  logic signed [DATA_W-1:0] data_rd_r;
  idx_t                     link_rd_r;
  idx_t                     used_head_r, free_head_r;
  idx_t                     cur_r, prev_r;
  idx_t                     clr_idx_r;
  idx_t                     count_r, count_nxt;
  idx_t                     raddr;
  idx_t                     waddr, wdata;
  logic                     wr_en;
  logic                     out_valid_r;
  logic [1:0]               out_status_r;
  logic [OUT_IDX_W-1:0]     out_node_index_r, out_item_count_r;
  idx_t                     emit_idx;

  always_comb begin
    case (cmd.rd_src)
      RD_FREE: raddr = free_head_r;
      RD_USED: raddr = used_head_r;
      RD_NEXT: raddr = link_rd_r;
      default: raddr = free_head_r;
    endcase
  end

  always_comb begin
    wr_en = 1'b0;
    waddr = clr_idx_r;
    wdata = '0;
    if (cmd.clr_wr) begin
      wr_en = 1'b1;
      waddr = clr_idx_r;
      wdata = (clr_idx_r == '0 || clr_idx_r == LAST_IDX) ? '0 : clr_idx_r + 1'b1;
    end else if (cmd.ins_commit) begin
      wr_en = 1'b1;
      waddr = free_head_r;
      wdata = used_head_r;
    end else if (cmd.unlink && prev_r != '0) begin
      wr_en = 1'b1;
      waddr = prev_r;
      wdata = link_rd_r;
    end else if (cmd.free_node) begin
      wr_en = 1'b1;
      waddr = cur_r;
      wdata = free_head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) link_mem[waddr] <= wdata;
    if (cmd.ins_commit) data_mem[free_head_r] <= value_r;
    if (cmd.rd_en) begin
      link_rd_r <= link_mem[raddr];
      data_rd_r <= data_mem[raddr];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins_commit) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.free_node && count_r != '0) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_comb begin
    emit_idx = '0;
    if (cmd.emit_st == ST_DONE) begin
      emit_idx = cmd.ins_commit ? free_head_r : cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r   <= '0;
      used_head_r <= '0;
      free_head_r <= FREE_TOP;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      count_r     <= count_nxt;
      if (cmd.clr_wr) clr_idx_r <= clr_idx_r + 1'b1;
      if (cmd.ins_commit) begin
        free_head_r <= link_rd_r;
        used_head_r <= free_head_r;
      end
      if (cmd.unlink && prev_r == '0) used_head_r <= link_rd_r;
      if (cmd.free_node) free_head_r <= cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) value_r <= in_value;
    if (cmd.walk_init) begin
      cur_r  <= used_head_r;
      prev_r <= '0;
    end else if (cmd.walk_adv) begin
      prev_r <= cur_r;
      cur_r  <= link_rd_r;
    end
    if (cmd.emit) begin
      out_status_r     <= cmd.emit_st;
      out_node_index_r <= to_out(emit_idx);
      out_item_count_r <= to_out(count_nxt);
    end
  end

  assign stat.clr_last   = (clr_idx_r == LAST_IDX);
  assign stat.free_empty = (free_head_r == '0);
  assign stat.used_empty = (used_head_r == '0);
  assign stat.match      = (data_rd_r == value_r);
  assign stat.next_zero  = (link_rd_r == '0);

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_node_index_r;
  assign out_item_count = out_item_count_r;

endmodule

// ----- rtl/static_linked_list_engine.sv -----
`timescale 1ns / 1ps
// Linked list over a fixed pool of nodes with a free list. A transaction is
// taken when start is high and busy is low; its result appears for exactly one
// cycle with out_valid and cannot be held off, so the receiver must take it
// then. After reset the node link memory is swept once, one entry a cycle,
// and busy stays high until the sweep ends, before the first transaction.
// An insert keeps busy high through a free-head read state and a commit state
// (only the first when the list is full), and its result shows in the first
// cycle with busy low. A delete walks the used list with one read of the node
// memories per cycle, and on a match goes on to unlink and free the node. The
// used list holds at most NODE_SLOTS - 2 nodes.
// The next transaction may be accepted while the previous result is shown.

module static_linked_list_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_op,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_node_index,
  output logic [6:0]         out_item_count
);
  import sll_pkg::*;

  sll_cmd_t  cmd;
  sll_stat_t stat;

  sll_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sll_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_value       (in_value),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_node_index (out_node_index),
    .out_item_count (out_item_count)
  );

endmodule

// ----- rtl/sll_checker.sv -----
`timescale 1ns / 1ps

module sll_props (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [6:0] out_node_index
);
  import sll_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_DONE |-> out_node_index == '0)
    else $error("failed transaction reports a node");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE || out_status == ST_FULL ||
                   out_status == ST_NOT_FOUND))
    else $error("undefined status code");

endmodule

bind static_linked_list_engine sll_props u_sll_props (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_node_index (out_node_index)
);

// ----- sim/sll_checker.sv -----
`timescale 1ns / 1ps

module sll_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic        in_op,
  input  logic [31:0] in_value,
  input  logic        out_valid,
  input  logic [1:0]  out_status,
  input  logic [6:0]  out_node_index,
  input  logic [6:0]  out_item_count,
  input  logic        end_check,
  output int          mismatch_count,
  output int          pend_count,
  output int          full_hits,
  output int          miss_hits
);
  import sll_pkg::*;

  localparam logic OP_INSERT = 1'b0;

  typedef struct {
    status_t    st;
    logic [6:0] idx;
    logic [6:0] cnt;
  } list_answer_t;

  idx_t         next_of [NODE_SLOTS];
  logic [31:0]  word_of [NODE_SLOTS];
  int           live_items;
  list_answer_t answers_due [$];
  bit           end_done;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic clear_pool();
    int i;
    for (i = 0; i < NODE_SLOTS; i++) begin
      word_of[i] = '0;
      next_of[i] = (i >= 1 && i < NODE_SLOTS - 1) ? idx_t'(i + 1) : idx_t'(0);
    end
    live_items = 0;
  endtask

  task automatic apply_list_op(input logic op, input logic [31:0] val,
                               output list_answer_t r);
    idx_t slot;
    idx_t prev;
    idx_t cur;
    int   steps;
    bit   hit;
    r.st  = ST_DONE;
    r.idx = '0;
    if (op == OP_INSERT) begin
      slot = next_of[1];
      if (slot == idx_t'(0) || slot == idx_t'(1)) begin
        r.st = ST_FULL;
      end else begin
        next_of[1]    = next_of[slot];
        next_of[slot] = next_of[0];
        next_of[0]    = slot;
        word_of[slot] = val;
        live_items++;
        r.idx = 7'(slot);
      end
    end else begin
      prev  = '0;
      cur   = next_of[0];
      steps = 0;
      hit   = 1'b0;
      while (!hit && cur != idx_t'(0) && steps < NODE_SLOTS) begin
        if (word_of[cur] == val) begin
          hit = 1'b1;
        end else begin
          prev = cur;
          cur  = next_of[cur];
          steps++;
        end
      end
      if (!hit) begin
        r.st = ST_NOT_FOUND;
      end else begin
        next_of[prev] = next_of[cur];
        next_of[cur]  = next_of[1];
        next_of[1]    = cur;
        if (live_items > 0) live_items--;
        r.idx = 7'(cur);
      end
    end
    r.cnt = 7'(live_items);
  endtask

  always @(posedge clk) begin : watch
    list_answer_t want;
    if (!rst_n) begin
      clear_pool();
      answers_due.delete();
      end_done = 1'b0;
    end else begin
      if (out_valid) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with none expected, status", 32'(out_status), 0);
        end else begin
          want = answers_due.pop_front();
          if (out_status !== want.st)
            report_mismatch("status", 32'(out_status), 32'(want.st));
          if (out_node_index !== want.idx)
            report_mismatch("node_index", 32'(out_node_index), 32'(want.idx));
          if (out_item_count !== want.cnt)
            report_mismatch("item_count", 32'(out_item_count), 32'(want.cnt));
        end
      end
      if (start && !busy) begin
        apply_list_op(in_op, in_value, want);
        if (want.st == ST_FULL) full_hits++;
        if (want.st == ST_NOT_FOUND) miss_hits++;
        answers_due.push_back(want);
      end
      if (end_check && !end_done) begin
        while (answers_due.size() > 0) begin
          want = answers_due.pop_front();
          report_mismatch("missing result, status", 0, 32'(want.st));
        end
        end_done = 1'b1;
      end
    end
    pend_count = answers_due.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import sll_pkg::*;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;
  localparam int   RANDOM_ITEMS = 2000;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               in_op;
  logic signed [31:0] in_value;
  logic               end_check;
  logic               busy;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [6:0]         out_node_index;
  logic [6:0]         out_item_count;

  int mismatch_count;
  int pend_count;
  int full_hits;
  int miss_hits;

  int          sent_inserts;
  int          sent_deletes;
  logic [31:0] live_vals [$];
  bit          calm;

  static_linked_list_engine dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_node_index(out_node_index),
    .out_item_count(out_item_count)
  );

  sll_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_op         (in_op),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_node_index(out_node_index),
    .out_item_count(out_item_count),
    .end_check     (end_check),
    .mismatch_count(mismatch_count),
    .pend_count    (pend_count),
    .full_hits     (full_hits),
    .miss_hits     (miss_hits)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic issue(input logic op, input logic [31:0] val);
    int gap;
    int k;
    bit gone;
    in_op    = op;
    in_value = val;
    start    = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    if (op == OP_INSERT) begin
      sent_inserts++;
      if (live_vals.size() < NODE_SLOTS - 2) live_vals.push_front(val);
    end else begin
      sent_deletes++;
      gone = 1'b0;
      for (k = 0; k < live_vals.size() && !gone; k++) begin
        if (live_vals[k] == val) begin
          live_vals.delete(k);
          gone = 1'b1;
        end
      end
    end
    if (!calm && $urandom_range(0, 99) < 14) begin
      start = 1'b0;
      gap   = $urandom_range(1, 40);
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin : stimulus
    int          n;
    int          ins_pct;
    int          guard;
    logic        op;
    logic [31:0] val;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_op     = OP_INSERT;
    in_value  = '0;
    end_check = 1'b0;
    calm      = 1'b0;
    sent_inserts = 0;
    sent_deletes = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // delete on empty, extremes, duplicates, head and tail removal
    issue(OP_DELETE, 32'd5);
    issue(OP_INSERT, 32'h8000_0000);
    issue(OP_INSERT, 32'h7FFF_FFFF);
    issue(OP_INSERT, 32'h0000_0000);
    issue(OP_INSERT, 32'hFFFF_FFFF);
    issue(OP_INSERT, 32'd42);
    issue(OP_INSERT, 32'd42);
    issue(OP_INSERT, 32'd7);
    issue(OP_DELETE, 32'd42);
    issue(OP_DELETE, 32'd42);
    issue(OP_DELETE, 32'd42);
    issue(OP_DELETE, 32'h8000_0000);
    issue(OP_DELETE, 32'd7);
    issue(OP_DELETE, 32'd99);
    issue(OP_INSERT, 32'h5555_5555);
    issue(OP_INSERT, 32'hAAAA_AAAA);
    issue(OP_DELETE, 32'hFFFF_FFFF);
    issue(OP_DELETE, 32'h0000_0000);
    issue(OP_DELETE, 32'h7FFF_FFFF);
    issue(OP_DELETE, 32'h5555_5555);
    issue(OP_DELETE, 32'hAAAA_AAAA);
    issue(OP_DELETE, 32'h0000_0000);

    // alternate fill, drain and mixed phases so the list hits full and empty
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 900 && n < 1300);
      case ((n / 250) % 3)
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 50;
      endcase
      op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
      if (op == OP_INSERT) begin
        val = ($urandom_range(0, 99) < 25) ? 32'($urandom_range(0, 7)) : $urandom();
      end else if (live_vals.size() > 0 && $urandom_range(0, 99) < 75) begin
        val = live_vals[$urandom_range(0, live_vals.size() - 1)];
      end else begin
        val = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 7)) : $urandom();
      end
      issue(op, val);
    end

    start = 1'b0;
    guard = 0;
    while (pend_count != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    repeat (150) @(negedge clk);
    end_check = 1'b1;
    repeat (2) @(negedge clk);

    $display("covered %0d inserts and %0d deletes, with %0d full-list and %0d not-found answers",
             sent_inserts, sent_deletes, full_hits, miss_hits);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sll_pkg.sv
rtl/sll_ctrl.sv
rtl/sll_datapath.sv
rtl/static_linked_list_engine.sv
rtl/sll_checker.sv
sim/sll_checker.sv
sim/tb_top.sv
